// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and gated by rst_ni.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge out of reset
`define SHUC_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Check that a condition in one cycle implies another in the next
`define SHUC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/shuc_pkg.sv =====
// ---------------------------------------------------------------------------
// shuc_pkg
// Types and constants shared by the host user id checker modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package shuc_pkg;

  localparam int unsigned ChrW      = 8;
  localparam int unsigned PrefixLen = 6;
  localparam int unsigned ReasonW   = 3;
  localparam int unsigned OutDataW  = 8;

  localparam logic [ChrW-1:0] ChrNul  = 8'h00;
  localparam logic [ChrW-1:0] ChrDash = 8'h2d;
  localparam logic [ChrW-1:0] ChrDot  = 8'h2e;

  // "ssh://", first character at index 0
  localparam logic [PrefixLen-1:0][ChrW-1:0] Prefix = {
    8'h2f, 8'h2f, 8'h3a, 8'h68, 8'h73, 8'h73
  };

  // Parser position: prefix characters 0..5, then label start, then in label
  typedef enum logic [2:0] {
    PH_P0          = 3'd0,
    PH_P1          = 3'd1,
    PH_P2          = 3'd2,
    PH_P3          = 3'd3,
    PH_P4          = 3'd4,
    PH_P5          = 3'd5,
    PH_LABEL_START = 3'd6,
    PH_IN_LABEL    = 3'd7
  } phase_e;

  typedef enum logic [ReasonW-1:0] {
    RSN_OK         = 3'd0,
    RSN_BAD_PREFIX = 3'd1,
    RSN_LABEL_BEG  = 3'd2,
    RSN_LABEL_END  = 3'd3,
    RSN_BAD_CHAR   = 3'd4,
    RSN_BAD_FINAL  = 3'd5
  } reason_e;

  // Character class word handed from the front to the back
  typedef struct packed {
    logic                 is_end;
    logic                 is_alnum;
    logic                 is_dash;
    logic                 is_dot;
    logic [PrefixLen-1:0] pfx_hit;
  } chr_class_t;

  localparam int unsigned ClassW = $bits(chr_class_t);

  function automatic logic is_alnum(input logic [ChrW-1:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h41) && (c <= 8'h5a)) ||
           ((c >= 8'h61) && (c <= 8'h7a));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/shuc_front.sv =====
// ---------------------------------------------------------------------------
// shuc_front
// Accepts input characters and classifies each into a class word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module shuc_front
  import shuc_pkg::*;
(
  input  wire logic             s_valid_i,
  output logic                  s_ready_o,
  input  wire logic [ChrW-1:0]  s_chr_i,
  input  wire logic             q_ready_i,
  output logic                  q_push_o,
  output chr_class_t            q_cls_o
);

  // Take a character whenever the queue has room
  assign s_ready_o = q_ready_i;
  assign q_push_o  = s_valid_i & q_ready_i;

  // Classify the character
  always_comb begin
    q_cls_o.is_end   = (s_chr_i == ChrNul);
    q_cls_o.is_alnum = is_alnum(s_chr_i);
    q_cls_o.is_dash  = (s_chr_i == ChrDash);
    q_cls_o.is_dot   = (s_chr_i == ChrDot);
    for (int i = 0; i < PrefixLen; i++) begin
      q_cls_o.pfx_hit[i] = (s_chr_i == Prefix[i]);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/shuc_queue.sv =====
// ---------------------------------------------------------------------------
// shuc_queue
// Two-entry queue of class words between the front and the back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module shuc_queue
  import shuc_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire chr_class_t push_cls_i,
  output logic            ready_o,
  input  wire logic       pop_i,
  output logic            valid_o,
  output chr_class_t      pop_cls_o
);

  chr_class_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign ready_o   = (cnt_q != 2'd2);
  assign valid_o   = (cnt_q != 2'd0);
  assign pop_cls_o = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cls_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/shuc_back.sv =====
// ---------------------------------------------------------------------------
// shuc_back
// Runs the syntax state machine on class words and holds the verdict word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module shuc_back
  import shuc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_valid_i,
  input  wire chr_class_t         q_cls_i,
  output logic                    q_pop_o,
  output logic                    m_valid_o,
  input  wire logic               m_ready_i,
  output logic [OutDataW-1:0]     m_data_o
);

  phase_e                   phase_q, phase_d;
  logic                     prev_an_q, prev_an_d;
  reason_e                  err_q, err_d;
  reason_e                  verdict;
  logic                     pfx_ok;
  logic                     out_vld_q;
  logic [OutDataW-1:0]      out_data_q;

  // Pop unless a verdict would overwrite one still waiting
  assign q_pop_o = q_valid_i & (!q_cls_i.is_end | !out_vld_q | m_ready_i);

  // Match against the expected prefix character
  always_comb begin
    pfx_ok = 1'b0;
    if (phase_q < PH_LABEL_START) begin
      pfx_ok = q_cls_i.pfx_hit[phase_q];
    end
  end

  // Next state
  always_comb begin
    phase_d   = phase_q;
    prev_an_d = prev_an_q;
    err_d     = err_q;
    if (q_pop_o) begin
      if (q_cls_i.is_end) begin
        phase_d   = PH_P0;
        prev_an_d = 1'b0;
        err_d     = RSN_OK;
      end else if (err_q == RSN_OK) begin
        unique case (phase_q)
          PH_LABEL_START: begin
            if (q_cls_i.is_alnum) begin
              phase_d   = PH_IN_LABEL;
              prev_an_d = 1'b1;
            end else begin
              err_d = RSN_LABEL_BEG;
            end
          end
          PH_IN_LABEL: begin
            priority if (q_cls_i.is_alnum || q_cls_i.is_dash) begin
              prev_an_d = q_cls_i.is_alnum;
            end else if (q_cls_i.is_dot) begin
              if (prev_an_q) begin
                phase_d   = PH_LABEL_START;
                prev_an_d = 1'b0;
              end else begin
                err_d = RSN_LABEL_END;
              end
            end else begin
              err_d = RSN_BAD_CHAR;
            end
          end
          default: begin
            if (pfx_ok) begin
              phase_d = phase_e'(phase_q + 3'd1);
            end else begin
              err_d = RSN_BAD_PREFIX;
            end
          end
        endcase
      end
    end
  end

  // Verdict for a terminating zero byte
  always_comb begin
    priority if (err_q != RSN_OK) begin
      verdict = err_q;
    end else if (phase_q < PH_LABEL_START) begin
      verdict = RSN_BAD_PREFIX;
    end else if (phase_q == PH_LABEL_START) begin
      verdict = RSN_BAD_FINAL;
    end else if (!prev_an_q) begin
      verdict = RSN_LABEL_END;
    end else begin
      verdict = RSN_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_P0;
      prev_an_q <= 1'b0;
      err_q     <= RSN_OK;
      out_vld_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      prev_an_q <= prev_an_d;
      err_q     <= err_d;
      if (q_pop_o && q_cls_i.is_end) begin
        out_vld_q <= 1'b1;
      end else if (m_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Load the verdict word
  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_cls_i.is_end) begin
      out_data_q <= {{(OutDataW - ReasonW - 1){1'b0}}, verdict, (verdict == RSN_OK)};
    end
  end

  assign m_valid_o = out_vld_q;
  assign m_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== rtl/core/ssh_hostname_userid_checker_unit.sv =====
// ---------------------------------------------------------------------------
// ssh_hostname_userid_checker_unit
// Syntax checker for ssh:// host user ids, one character per word.
// ---------------------------------------------------------------------------
// Takes one character per clock on the slave stream while the queue has
// room; a zero byte ends the string and yields one verdict word on the
// master stream via the queue and the verdict register, other characters
// yield nothing. The rate is set by the combinational class lookup in the
// front and the registered state update in the back; a two-entry queue and
// the verdict register let input keep flowing while a verdict waits to be
// taken. Verdict word: bit 0 = valid_res, bits 3:1 = reason (0 ok, 1 bad
// prefix, 2 bad label start, 3 bad label end, 4 bad character, 5 bad final
// character), upper bits zero. The first error is kept until the zero byte.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssh_hostname_userid_checker_unit
  import shuc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [ChrW-1:0]     s_axis_tdata,   // [7:0] ch
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata    // [0] valid_res, [3:1] reason, [7:4] zero
);

  logic       q_ready;
  logic       q_push;
  chr_class_t push_cls;
  logic       q_valid;
  logic       q_pop;
  chr_class_t pop_cls;

  shuc_front u_front (
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_chr_i   (s_axis_tdata),
    .q_ready_i (q_ready),
    .q_push_o  (q_push),
    .q_cls_o   (push_cls)
  );

  shuc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cls_i (push_cls),
    .ready_o    (q_ready),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .pop_cls_o  (pop_cls)
  );

  shuc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_cls_i   (pop_cls),
    .q_pop_o   (q_pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ===== rtl/core/shuc_checker.sv =====
// ---------------------------------------------------------------------------
// shuc_checker
// Port-level checks of the verdict stream, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module shuc_checker
  import shuc_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OutDataW-1:0] m_axis_tdata
);

  logic [ReasonW-1:0] rsn;

  assign rsn = m_axis_tdata[ReasonW:1];

  // Hold a stalled verdict word
  `SHUC_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "verdict dropped or changed while stalled")

  // Flag and reason agree
  `SHUC_ASSERT_ALWAYS(a_flag, !m_axis_tvalid || (m_axis_tdata[0] == (rsn == RSN_OK)), "valid flag disagrees with reason")

  // Reason is a defined code
  `SHUC_ASSERT_ALWAYS(a_code, !m_axis_tvalid || (rsn <= RSN_BAD_FINAL), "reason code out of range")

  // Pad bits stay zero
  `SHUC_ASSERT_ALWAYS(a_pad, !m_axis_tvalid || (m_axis_tdata[OutDataW-1:ReasonW+1] == '0), "pad bits set")

endmodule

bind ssh_hostname_userid_checker_unit shuc_checker u_shuc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
